@@ design/htfc_pkg.sv @@
`timescale 1ns / 1ps

package htfc_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned CrcW   = 8;
  localparam int unsigned ValueW = 15;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CoefW  = 15;

  localparam logic [CrcW-1:0] CRC_POLY = 8'h31;
  localparam logic [RawW-1:0] RAW_MASK = 16'hFFFC;

  // Scale factors, both applied as (coef * r) >> 16
  localparam logic [CoefW-1:0] TEMP_COEF = 15'd17572;
  localparam logic [CoefW-1:0] HUM_COEF  = 15'd12500;
  localparam logic signed [15:0] TEMP_OFFSET = -16'sd4685;
  localparam logic signed [15:0] HUM_OFFSET  = -16'sd600;

  // Humidity compensation: (T - 2500) * 39322 >> 18, about 0.15 per 0.01 C
  localparam logic signed [15:0] COMP_REF   = 16'sd2500;
  localparam logic signed [16:0] COMP_COEF  = 17'sd39322;
  localparam int unsigned        COMP_SHIFT = 18;

  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_HUM  = 1'b1;

  localparam logic [StatW-1:0] STATUS_OK      = 2'd0;
  localparam logic [StatW-1:0] STATUS_CRC     = 2'd1;
  localparam logic [StatW-1:0] STATUS_NO_TEMP = 2'd2;

  typedef struct packed {
    logic            cmd;
    logic [RawW-1:0] raw_word;
    logic [CrcW-1:0] check_byte;
  } frame_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [StatW-1:0]         status;
    logic                     kind;
  } result_t;

  // One byte through the MSB-first CRC-8 shift register
  function automatic logic [CrcW-1:0] crc8_byte(logic [CrcW-1:0] crc_in,
                                                logic [7:0] data);
    logic [CrcW-1:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ design/htfc_crc8.sv @@
`timescale 1ns / 1ps

module htfc_crc8 (
  input  logic [htfc_pkg::RawW-1:0] raw_word_i,
  input  logic [htfc_pkg::CrcW-1:0] check_byte_i,
  output logic                      crc_ok_o
);
  import htfc_pkg::*;

  logic [CrcW-1:0] crc_hi;
  logic [CrcW-1:0] crc_full;

  // high byte goes first on the wire
  assign crc_hi   = crc8_byte('0, raw_word_i[15:8]);
  assign crc_full = crc8_byte(crc_hi, raw_word_i[7:0]);
  assign crc_ok_o = (crc_full == check_byte_i);

endmodule

@@ design/htfc_convert.sv @@
`timescale 1ns / 1ps

module htfc_convert (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  htfc_pkg::frame_t frame_i,
  input  logic             crc_ok_i,
  output htfc_pkg::result_t result_o
);
  import htfc_pkg::*;

  logic signed [ValueW-1:0] last_temp_q, last_temp_d;
  logic                     temp_valid_q, temp_valid_d;

  logic [RawW-1:0]          r;
  logic [CoefW-1:0]         coef;
  logic [RawW+CoefW-1:0]    prod;
  logic [CoefW-1:0]         scaled;
  logic signed [15:0]       offset;
  logic signed [15:0]       base;
  logic signed [15:0]       diff;
  logic signed [32:0]       comp_prod;
  logic signed [ValueW-1:0] comp;
  logic signed [ValueW-1:0] base_v;

  assign r      = frame_i.raw_word & RAW_MASK;
  assign coef   = (frame_i.cmd == KIND_HUM) ? HUM_COEF : TEMP_COEF;
  assign offset = (frame_i.cmd == KIND_HUM) ? HUM_OFFSET : TEMP_OFFSET;
  assign prod   = r * coef;
  assign scaled = prod[RawW+CoefW-1:RawW];
  assign base   = $signed({1'b0, scaled}) + offset;
  assign base_v = base[ValueW-1:0];

  // Compensation depends only on the stored temperature
  assign diff      = $signed({last_temp_q[ValueW-1], last_temp_q}) - COMP_REF;
  assign comp_prod = diff * COMP_COEF;
  // arithmetic shift floors toward minus infinity
  assign comp      = comp_prod[COMP_SHIFT+ValueW-1:COMP_SHIFT];

  always_comb begin
    result_o.kind   = frame_i.cmd;
    result_o.value  = '0;
    result_o.status = STATUS_OK;
    last_temp_d     = last_temp_q;
    temp_valid_d    = temp_valid_q;
    priority if (!crc_ok_i) begin
      result_o.status = STATUS_CRC;
      if (frame_i.cmd == KIND_TEMP) begin
        temp_valid_d = 1'b0;
      end
    end else if (frame_i.cmd == KIND_TEMP) begin
      result_o.value = base_v;
      last_temp_d    = base_v;
      temp_valid_d   = 1'b1;
    end else if (temp_valid_q) begin
      result_o.value = base_v + comp;
    end else begin
      result_o.value  = base_v;
      result_o.status = STATUS_NO_TEMP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_temp_q  <= '0;
      temp_valid_q <= 1'b0;
    end else if (fire_i) begin
      last_temp_q  <= last_temp_d;
      temp_valid_q <= temp_valid_d;
    end
  end

endmodule

@@ design/humidity_temp_frame_convert.sv @@
`timescale 1ns / 1ps
// Channel | Handshake               | Payload
// --------+-------------------------+-----------------------------------
// input   | in_valid_i / in_ready_o | cmd_i, raw_word_i, check_byte_i
// output  | out_valid_o/ out_ready_i| value_o, status_o, kind_o
//
// One frame per clock sustained while the output is not stalled. The path is
// an input register, then CRC check, one constant multiply and the compensation
// multiply into the result register. The stored temperature updates as a frame
// moves into the result register, so the next frame sees it without a gap.
// Reset clears both stages and the stored temperature; a stalled output keeps
// its result and the input register holds one more frame before ready drops.

module humidity_temp_frame_convert (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             cmd_i,
  input  logic [htfc_pkg::RawW-1:0]        raw_word_i,
  input  logic [htfc_pkg::CrcW-1:0]        check_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [htfc_pkg::ValueW-1:0] value_o,
  output logic [htfc_pkg::StatW-1:0]       status_o,
  output logic                             kind_o
);
  import htfc_pkg::*;

  logic    s1_valid_q;
  frame_t  s1_frame_q;
  logic    out_valid_q;
  result_t out_q;
  result_t conv_result;
  logic    crc_ok;
  logic    out_free;
  logic    s1_fire;
  logic    in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  htfc_crc8 u_crc (
    .raw_word_i   (s1_frame_q.raw_word),
    .check_byte_i (s1_frame_q.check_byte),
    .crc_ok_o     (crc_ok)
  );

  htfc_convert u_convert (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .frame_i  (s1_frame_q),
    .crc_ok_i (crc_ok),
    .result_o (conv_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_frame_q <= '{cmd: cmd_i, raw_word: raw_word_i, check_byte: check_byte_i};
    end
    if (s1_fire) begin
      out_q <= conv_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_q.value;
  assign status_o    = out_q.status;
  assign kind_o      = out_q.kind;

endmodule

@@ design/htfc_checker.sv @@
`timescale 1ns / 1ps

module htfc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               cmd_i,
  input logic [htfc_pkg::RawW-1:0]          raw_word_i,
  input logic [htfc_pkg::CrcW-1:0]          check_byte_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [htfc_pkg::ValueW-1:0] value_o,
  input logic [htfc_pkg::StatW-1:0]         status_o,
  input logic                               kind_o
);
  import htfc_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(value_o) && $stable(status_o) && $stable(kind_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_OK || status_o == STATUS_CRC ||
                     status_o == STATUS_NO_TEMP))
    else $error("undefined status code");

  a_crc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_CRC |-> value_o == '0)
    else $error("CRC failure with nonzero value");

  a_no_temp_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_NO_TEMP |-> kind_o == KIND_HUM)
    else $error("missing-temperature status on a temperature frame");

  // no result can appear without an earlier accepted frame
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o || in_valid_i, 2) || $past(!in_ready_o, 1))
    else $error("result without a frame");

endmodule

bind humidity_temp_frame_convert htfc_checker u_checker (.*);

@@ verif/humidity_temp_frame_convert_tb.sv @@
`timescale 1ns / 1ps

module humidity_temp_frame_convert_tb;
  import htfc_pkg::*;

  localparam logic [7:0]  CHECK_POLY   = 8'h31;
  localparam int unsigned TEMP_SCALE   = 17572;
  localparam int unsigned HUM_SCALE    = 12500;
  localparam int          TEMP_BASE    = -4685;
  localparam int          HUM_BASE     = -600;
  localparam int          COMP_CENTER  = 2500;
  localparam longint      COMP_FACTOR  = 39322;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     cmd_i = KIND_TEMP;
  logic [RawW-1:0]          raw_word_i = '0;
  logic [CrcW-1:0]          check_byte_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b1;
  logic signed [ValueW-1:0] value_o;
  logic [StatW-1:0]         status_o;
  logic                     kind_o;

  // Predictor state, tracked in acceptance order
  logic signed [ValueW-1:0] stored_temp = '0;
  logic                     stored_temp_ok = 1'b0;

  result_t pending_results[$];
  result_t want;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int temp_frames = 0;
  int hum_frames = 0;
  int bad_check_frames = 0;
  int no_temp_results = 0;

  humidity_temp_frame_convert u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .raw_word_i  (raw_word_i),
    .check_byte_i(check_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .kind_o      (kind_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Bit-serial CRC-8, MSB first, zero seed
  function automatic logic [7:0] frame_checksum(logic [15:0] raw);
    logic [7:0] acc;
    logic       fb;
    acc = '0;
    for (int b = 15; b >= 0; b--) begin
      fb  = acc[7] ^ raw[b];
      acc = {acc[6:0], 1'b0} ^ (fb ? CHECK_POLY : 8'h00);
    end
    return acc;
  endfunction

  function automatic result_t convert_frame(logic cmd, logic [15:0] raw, logic [7:0] chk);
    result_t     res;
    logic [15:0] r;
    int          temp;
    int          hum;
    longint      comp;
    r = raw & 16'hFFFC;
    res.value  = '0;
    res.status = STATUS_OK;
    res.kind   = cmd;
    if (frame_checksum(raw) != chk) begin
      res.status = STATUS_CRC;
      if (cmd == KIND_TEMP) begin
        stored_temp_ok = 1'b0;
      end
    end else if (cmd == KIND_TEMP) begin
      temp = TEMP_BASE + int'((TEMP_SCALE * 32'(r)) >> 16);
      stored_temp    = temp[ValueW-1:0];
      stored_temp_ok = 1'b1;
      res.value      = temp[ValueW-1:0];
    end else begin
      hum = HUM_BASE + int'((HUM_SCALE * 32'(r)) >> 16);
      if (stored_temp_ok) begin
        // arithmetic shift gives floor for negative products
        comp = (longint'(stored_temp) - COMP_CENTER) * COMP_FACTOR;
        hum  = hum + int'(comp >>> 18);
      end else begin
        res.status = STATUS_NO_TEMP;
      end
      res.value = hum[ValueW-1:0];
    end
    return res;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction completes
  task automatic send_frame(input logic cmd, input logic [15:0] raw, input logic [7:0] chk);
    result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    raw_word_i   <= raw;
    check_byte_i <= chk;
    do @(posedge clk_i); while (!in_ready_o);
    res = convert_frame(cmd, raw, chk);
    pending_results.push_back(res);
    if (cmd == KIND_TEMP) temp_frames++;
    else hum_frames++;
    if (res.status == STATUS_CRC) bad_check_frames++;
    if (res.status == STATUS_NO_TEMP) no_temp_results++;
  endtask

  task automatic send_good(input logic cmd, input logic [15:0] raw);
    send_frame(cmd, raw, frame_checksum(raw));
  endtask

  task automatic send_corrupt(input logic cmd, input logic [15:0] raw);
    send_frame(cmd, raw, frame_checksum(raw) ^ 8'($urandom_range(255, 1)));
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_humidity_without_temperature();
    send_good(KIND_HUM, 16'h8000);
    send_good(KIND_HUM, 16'hFFFF);
    send_corrupt(KIND_HUM, 16'h1234);   // checksum error outranks missing temperature
  endtask

  task automatic test_temperature_range();
    send_good(KIND_TEMP, 16'h0000);
    send_good(KIND_TEMP, 16'h0003);     // status bits only
    send_good(KIND_TEMP, 16'hFFFC);
    send_good(KIND_TEMP, 16'hFFFF);
    send_good(KIND_TEMP, 16'h6666);
  endtask

  task automatic test_humidity_compensation();
    send_good(KIND_TEMP, 16'h0000);     // coldest reading
    send_good(KIND_HUM, 16'h0000);
    send_good(KIND_HUM, 16'hFFFF);
    send_good(KIND_TEMP, 16'hFFFF);     // hottest reading
    send_good(KIND_HUM, 16'h0000);
    send_good(KIND_HUM, 16'hFFFF);
    send_good(KIND_TEMP, 16'h68AD);     // close to 25 C, near-zero correction
    send_good(KIND_HUM, 16'h7FFF);
  endtask

  task automatic test_checksum_errors();
    send_frame(KIND_TEMP, 16'h0000, 8'hFF);  // bad temperature drops the stored one
    send_good(KIND_HUM, 16'h4000);
    send_good(KIND_TEMP, 16'hA000);
    send_frame(KIND_HUM, 16'h5555, frame_checksum(16'h5555) ^ 8'h80);
    send_good(KIND_HUM, 16'h5555);           // still compensated
  endtask

  task automatic test_random_frames(input int count, input int idle_pct, input int hold_pct);
    logic        cmd;
    logic [15:0] raw;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    for (int n = 0; n < count; n++) begin
      cmd = ($urandom_range(99) < 60) ? KIND_HUM : KIND_TEMP;
      raw = 16'($urandom_range(65535));
      if ($urandom_range(99) < 15) send_corrupt(cmd, raw);
      else send_good(cmd, raw);
    end
  endtask

  task automatic test_pause_until_drained();
    send_good(KIND_TEMP, 16'($urandom_range(65535)));
    send_good(KIND_HUM, 16'($urandom_range(65535)));
    hold_until_drained();
    send_good(KIND_HUM, 16'($urandom_range(65535)));
    send_good(KIND_TEMP, 16'($urandom_range(65535)));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d status %0d kind %0d",
                 $time, value_o, status_o, kind_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (value_o !== want.value) begin
          $display("%0t: value mismatch, expected %0d, got %0d", $time, want.value, value_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status_o);
          mismatch_count++;
        end
        if (kind_o !== want.kind) begin
          $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, kind_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_humidity_without_temperature();
    test_temperature_range();
    test_humidity_compensation();
    test_checksum_errors();
    test_random_frames(475, 0, 0);
    test_random_frames(475, 57, 0);
    test_pause_until_drained();
    test_random_frames(475, 0, 57);
    test_random_frames(475, 37, 37);

    hold_until_drained();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d temperature and %0d humidity frames, %0d with bad checksums,",
             temp_frames, hum_frames, bad_check_frames);
    $display("%0d humidity results without a stored temperature, under four idle patterns",
             no_temp_results);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ humidity_temp_frame_convert.f @@
design/htfc_pkg.sv
design/htfc_crc8.sv
design/htfc_convert.sv
design/humidity_temp_frame_convert.sv
design/htfc_checker.sv
verif/humidity_temp_frame_convert_tb.sv
